// File: rtl/shmp_pkg.sv
`default_nettype none

package shmp_pkg;

    localparam int unsigned MAX_OPERATION_MODES_DEF   = 16;
    localparam int unsigned MAX_INPUT_SIGNALS_DEF     = 16;
    localparam int unsigned MAX_CALIBRATION_PARTS_DEF = 16;

    localparam int unsigned HEADER_BYTES = 24;

    localparam int unsigned PHASE_W = 4;

    localparam logic [PHASE_W-1:0] PH_HDR    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_NOP    = 4'd1;
    localparam logic [PHASE_W-1:0] PH_OPM    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_DEF1   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_DEF2   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_VOLT   = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TEMP   = 4'd6;
    localparam logic [PHASE_W-1:0] PH_NIN    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_INTYPE = 4'd8;
    localparam logic [PHASE_W-1:0] PH_INSTAT = 4'd9;
    localparam logic [PHASE_W-1:0] PH_SYNC   = 4'd10;
    localparam logic [PHASE_W-1:0] PH_NCAL   = 4'd11;
    localparam logic [PHASE_W-1:0] PH_CALC   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_CALS   = 4'd13;
    localparam logic [PHASE_W-1:0] PH_CALST  = 4'd14;
    localparam logic [PHASE_W-1:0] PH_DONE   = 4'd15;

    localparam logic [4:0] FID_NONE          = 5'd0;
    localparam logic [4:0] FID_VERSION_MAJOR = 5'd1;
    localparam logic [4:0] FID_TIMESTAMP     = 5'd7;
    localparam logic [4:0] FID_MSG_COUNTER   = 5'd8;
    localparam logic [4:0] FID_CYCLE_TIME    = 5'd9;
    localparam logic [4:0] FID_CYCLE_VAR     = 5'd10;
    localparam logic [4:0] FID_QUALIFIER     = 5'd11;
    localparam logic [4:0] FID_OPM_COUNT     = 5'd12;
    localparam logic [4:0] FID_OPM           = 5'd13;
    localparam logic [4:0] FID_DEFECT        = 5'd14;
    localparam logic [4:0] FID_DEFECT_REASON = 5'd15;
    localparam logic [4:0] FID_VOLTAGE       = 5'd16;
    localparam logic [4:0] FID_TEMPERATURE   = 5'd17;
    localparam logic [4:0] FID_SIG_COUNT     = 5'd18;
    localparam logic [4:0] FID_SIG_TYPE      = 5'd19;
    localparam logic [4:0] FID_SIG_STATUS    = 5'd20;
    localparam logic [4:0] FID_TIME_SYNC     = 5'd21;
    localparam logic [4:0] FID_CAL_COUNT     = 5'd22;
    localparam logic [4:0] FID_CAL_COMP      = 5'd23;
    localparam logic [4:0] FID_CAL_STATUS    = 5'd24;
    localparam logic [4:0] FID_CAL_STATE     = 5'd25;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_id;
        logic [7:0]  element_index;
        logic [63:0] field_value;
        logic        done_res;
        logic        status;
    } out_item_t;

endpackage

`default_nettype wire

// File: rtl/shmp_decoder.sv
`default_nettype none

module shmp_decoder #(
    parameter int unsigned MAX_OPERATION_MODES   = shmp_pkg::MAX_OPERATION_MODES_DEF,
    parameter int unsigned MAX_INPUT_SIGNALS     = shmp_pkg::MAX_INPUT_SIGNALS_DEF,
    parameter int unsigned MAX_CALIBRATION_PARTS = shmp_pkg::MAX_CALIBRATION_PARTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_accept,
    input  wire shmp_pkg::in_item_t  in_item,
    output logic                     res_valid,
    output shmp_pkg::out_item_t      res_item
);
    import shmp_pkg::*;

    localparam logic [7:0] MAX_OPM_C = 8'(MAX_OPERATION_MODES);
    localparam logic [7:0] MAX_SIG_C = 8'(MAX_INPUT_SIGNALS);
    localparam logic [7:0] MAX_CAL_C = 8'(MAX_CALIBRATION_PARTS);
    localparam logic [7:0] HDR_LAST  = 8'(HEADER_BYTES - 1);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         pos_reg, pos_next;
    logic [7:0]         count_reg, count_next;
    logic [63:0]        asm_reg, asm_next;
    logic               complete_reg, complete_next;

    logic [7:0]  b;
    logic        last;
    logic        emit;
    logic        adv_done;
    logic [7:0]  pos_inc;
    logic [7:0]  start;
    logic [2:0]  lane;
    logic [63:0] asm_sum;
    logic [7:0]  clamp_opm, clamp_sig, clamp_cal;

    assign b    = in_item.data_byte;
    assign last = in_item.last_byte;

    assign pos_inc  = pos_reg + 8'd1;
    assign adv_done = ({1'b0, pos_reg} + 9'd1) >= {1'b0, count_reg};

    assign start   = (pos_reg < 8'd14) ? 8'd6 : (pos_reg < 8'd18) ? 8'd14 : 8'd18;
    assign lane    = 3'(pos_reg - start);
    assign asm_sum = asm_reg | ({56'd0, b} << {lane, 3'b000});

    assign clamp_opm = (b > MAX_OPM_C) ? MAX_OPM_C : b;
    assign clamp_sig = (b > MAX_SIG_C) ? MAX_SIG_C : b;
    assign clamp_cal = (b > MAX_CAL_C) ? MAX_CAL_C : b;

    always_comb begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        count_next    = count_reg;
        asm_next      = asm_reg;
        complete_next = complete_reg;
        emit          = 1'b0;
        res_item      = '0;

        unique case (phase_reg)
            PH_HDR: begin
                if (pos_reg < 8'd6) begin
                    res_item.field_id    = FID_VERSION_MAJOR + pos_reg[4:0];
                    res_item.field_value = {56'd0, b};
                    emit                 = 1'b1;
                end else if (pos_reg < 8'd22) begin
                    asm_next = asm_sum;
                    if (pos_reg == 8'd13 || pos_reg == 8'd17 || pos_reg == 8'd21) begin
                        res_item.field_id    = (pos_reg == 8'd13) ? FID_TIMESTAMP :
                                               (pos_reg == 8'd17) ? FID_MSG_COUNTER :
                                                                    FID_CYCLE_TIME;
                        res_item.field_value = asm_sum;
                        asm_next             = '0;
                        emit                 = 1'b1;
                    end
                end else begin
                    res_item.field_id    = (pos_reg == 8'd22) ? FID_CYCLE_VAR : FID_QUALIFIER;
                    res_item.field_value = {56'd0, b};
                    emit                 = 1'b1;
                end
                if (pos_reg >= HDR_LAST) begin
                    pos_next   = '0;
                    phase_next = PH_NOP;
                end else begin
                    pos_next = pos_inc;
                end
            end
            PH_NOP: begin
                res_item.field_id    = FID_OPM_COUNT;
                res_item.field_value = {56'd0, clamp_opm};
                emit                 = 1'b1;
                count_next           = clamp_opm;
                pos_next             = '0;
                phase_next           = (clamp_opm != 8'd0) ? PH_OPM : PH_DEF1;
            end
            PH_OPM: begin
                res_item.field_id      = FID_OPM;
                res_item.element_index = pos_reg;
                res_item.field_value   = {56'd0, b};
                emit                   = 1'b1;
                pos_next               = adv_done ? 8'd0 : pos_inc;
                phase_next             = adv_done ? PH_DEF1 : phase_reg;
            end
            PH_DEF1: begin
                res_item.field_id    = FID_DEFECT;
                res_item.field_value = {56'd0, b};
                emit                 = 1'b1;
                phase_next           = PH_DEF2;
            end
            PH_DEF2: begin
                res_item.field_id    = FID_DEFECT_REASON;
                res_item.field_value = {56'd0, b};
                emit                 = 1'b1;
                phase_next           = PH_VOLT;
            end
            PH_VOLT: begin
                res_item.field_id    = FID_VOLTAGE;
                res_item.field_value = {56'd0, b};
                emit                 = 1'b1;
                phase_next           = PH_TEMP;
            end
            PH_TEMP: begin
                res_item.field_id    = FID_TEMPERATURE;
                res_item.field_value = {56'd0, b};
                emit                 = 1'b1;
                phase_next           = PH_NIN;
            end
            PH_NIN: begin
                res_item.field_id    = FID_SIG_COUNT;
                res_item.field_value = {56'd0, clamp_sig};
                emit                 = 1'b1;
                count_next           = clamp_sig;
                pos_next             = '0;
                phase_next           = (clamp_sig != 8'd0) ? PH_INTYPE : PH_SYNC;
            end
            PH_INTYPE: begin
                res_item.field_id      = FID_SIG_TYPE;
                res_item.element_index = pos_reg;
                res_item.field_value   = {56'd0, b};
                emit                   = 1'b1;
                pos_next               = adv_done ? 8'd0 : pos_inc;
                phase_next             = adv_done ? PH_INSTAT : phase_reg;
            end
            PH_INSTAT: begin
                res_item.field_id      = FID_SIG_STATUS;
                res_item.element_index = pos_reg;
                res_item.field_value   = {56'd0, b};
                emit                   = 1'b1;
                pos_next               = adv_done ? 8'd0 : pos_inc;
                phase_next             = adv_done ? PH_SYNC : phase_reg;
            end
            PH_SYNC: begin
                res_item.field_id    = FID_TIME_SYNC;
                res_item.field_value = {56'd0, b};
                emit                 = 1'b1;
                phase_next           = PH_NCAL;
            end
            PH_NCAL: begin
                res_item.field_id    = FID_CAL_COUNT;
                res_item.field_value = {56'd0, clamp_cal};
                emit                 = 1'b1;
                count_next           = clamp_cal;
                pos_next             = '0;
                if (clamp_cal != 8'd0) begin
                    phase_next = PH_CALC;
                end else begin
                    phase_next    = PH_DONE;
                    complete_next = 1'b1;
                end
            end
            PH_CALC: begin
                res_item.field_id      = FID_CAL_COMP;
                res_item.element_index = pos_reg;
                res_item.field_value   = {56'd0, b};
                emit                   = 1'b1;
                pos_next               = adv_done ? 8'd0 : pos_inc;
                phase_next             = adv_done ? PH_CALS : phase_reg;
            end
            PH_CALS: begin
                res_item.field_id      = FID_CAL_STATUS;
                res_item.element_index = pos_reg;
                res_item.field_value   = {56'd0, b};
                emit                   = 1'b1;
                pos_next               = adv_done ? 8'd0 : pos_inc;
                phase_next             = adv_done ? PH_CALST : phase_reg;
            end
            PH_CALST: begin
                res_item.field_id      = FID_CAL_STATE;
                res_item.element_index = pos_reg;
                res_item.field_value   = {56'd0, b};
                emit                   = 1'b1;
                if (adv_done) begin
                    pos_next      = '0;
                    phase_next    = PH_DONE;
                    complete_next = 1'b1;
                end else begin
                    pos_next = pos_inc;
                end
            end
            default: begin
                phase_next    = PH_DONE;
                complete_next = 1'b1;
            end
        endcase

        res_item.done_res = last;
        res_item.status   = last && !complete_next;
        res_valid         = emit || last;

        // The last byte ends the message and returns every register to its reset value.
        if (last) begin
            phase_next    = PH_HDR;
            pos_next      = '0;
            count_next    = '0;
            asm_next      = '0;
            complete_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR;
            pos_reg      <= '0;
            count_reg    <= '0;
            asm_reg      <= '0;
            complete_reg <= 1'b0;
        end else if (in_accept) begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            count_reg    <= count_next;
            asm_reg      <= asm_next;
            complete_reg <= complete_next;
        end
    end

`ifndef SYNTHESIS
    a_array_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_OPM || phase_reg == PH_INTYPE || phase_reg == PH_INSTAT ||
         phase_reg == PH_CALC || phase_reg == PH_CALS || phase_reg == PH_CALST)
        |-> (count_reg != 8'd0 && pos_reg < count_reg))
        else $error("array position outside the section count");

    a_asm_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HDR) |-> (asm_reg == 64'd0))
        else $error("assembler holds bits outside the header");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_item.last_byte) |=>
        (phase_reg == PH_HDR && pos_reg == 8'd0 && !complete_reg))
        else $error("state not cleared after the last byte");

    a_done_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE) |-> complete_reg)
        else $error("done phase without a complete structure");
`endif

endmodule

`default_nettype wire

// File: rtl/sensor_health_message_parser_top.sv
// Sensor health message parser.
// The input channel (s_valid, s_ready, s_data) carries one payload byte per
// transaction, with last_byte set on the final byte of a message. The result
// channel (m_valid, m_ready, m_data) carries one decoded field per transaction:
// the field code, the element index inside counted sections, and the value,
// with multi-byte header fields assembled little-endian and counts clamped.
// The final byte of a message always yields a result with done_res set, and
// status reports whether the message was truncated.
// Bytes that do not complete a field, and trailing bytes after a complete
// structure, produce no result.
// An accepted byte's result is registered and appears on m_data in the next cycle.
// Throughput is one byte per cycle while the receiver does not stall: the decode is a single pass of logic from
// the parser state and the input byte into the output register.
// When the receiver stalls, the output register holds its result and s_ready
// drops until it is taken; s_ready is high whenever that register is empty or
// being drained in the same cycle.
// A synchronous active-low reset on aresetn empties the output register and
// returns the parser to the start of a message.
`default_nettype none

module sensor_health_message_parser_top #(
    parameter int unsigned MAX_OPERATION_MODES   = shmp_pkg::MAX_OPERATION_MODES_DEF,
    parameter int unsigned MAX_INPUT_SIGNALS     = shmp_pkg::MAX_INPUT_SIGNALS_DEF,
    parameter int unsigned MAX_CALIBRATION_PARTS = shmp_pkg::MAX_CALIBRATION_PARTS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire shmp_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output shmp_pkg::out_item_t      m_data
);
    import shmp_pkg::*;

    logic      in_accept;
    logic      res_valid;
    out_item_t res_item;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    shmp_decoder #(
        .MAX_OPERATION_MODES   (MAX_OPERATION_MODES),
        .MAX_INPUT_SIGNALS     (MAX_INPUT_SIGNALS),
        .MAX_CALIBRATION_PARTS (MAX_CALIBRATION_PARTS)
    ) u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= in_accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && res_valid) begin
            m_data_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: dv/shm_decode_checker.sv
`default_nettype none

module shm_decode_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire shmp_pkg::in_item_t  s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire shmp_pkg::out_item_t m_data,
    output int unsigned              mismatch_count,
    output int unsigned              pending_count,
    output int unsigned              checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import shmp_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    logic [PHASE_W-1:0] phase_q;
    logic [7:0]         pos_q;
    logic [7:0]         count_q;
    logic [63:0]        asm_q;
    logic               complete_q;

    out_item_t expected_fields[$];

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        checked_count  = 0;
    end

    task automatic clear_decode_state();
        phase_q    = PH_HDR;
        pos_q      = '0;
        count_q    = '0;
        asm_q      = '0;
        complete_q = 1'b0;
    endtask

    function automatic logic [7:0] clamp_count(input logic [7:0] c, input int unsigned maxv);
        return (c > maxv) ? maxv[7:0] : c;
    endfunction

    task automatic enter_section(input logic [7:0] c, input logic [PHASE_W-1:0] arr_phase,
                                 input logic [PHASE_W-1:0] skip_phase);
        count_q = c;
        pos_q   = '0;
        phase_q = (c != 0) ? arr_phase : skip_phase;
    endtask

    task automatic step_element(input logic [PHASE_W-1:0] next_phase);
        pos_q = pos_q + 8'd1;
        if (pos_q >= count_q) begin
            pos_q   = '0;
            phase_q = next_phase;
            if (next_phase == PH_DONE) begin
                complete_q = 1'b1;
            end
        end
    endtask

    task automatic decode_byte(input in_item_t item);
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  pos;
        logic [7:0]  start_pos;
        logic [4:0]  fid;
        logic [7:0]  idx;
        logic [63:0] val;
        logic        emit;
        out_item_t   res;
        b    = item.data_byte;
        pos  = pos_q;
        fid  = FID_NONE;
        idx  = '0;
        val  = '0;
        emit = 1'b0;
        case (phase_q)
            PH_HDR: begin
                if (pos < 6) begin
                    fid  = FID_VERSION_MAJOR + pos[4:0];
                    val  = {56'd0, b};
                    emit = 1'b1;
                end else if (pos < 22) begin
                    start_pos = (pos < 14) ? 8'd6 : (pos < 18) ? 8'd14 : 8'd18;
                    asm_q = asm_q | ({56'd0, b} << (((pos - start_pos) & 8'd7) * 8));
                    if (pos == 13 || pos == 17 || pos == 21) begin
                        fid = (pos < 14) ? FID_TIMESTAMP :
                              (pos < 18) ? FID_MSG_COUNTER : FID_CYCLE_TIME;
                        val   = asm_q;
                        asm_q = '0;
                        emit  = 1'b1;
                    end
                end else begin
                    fid  = (pos == 22) ? FID_CYCLE_VAR : FID_QUALIFIER;
                    val  = {56'd0, b};
                    emit = 1'b1;
                end
                if (pos >= HEADER_BYTES - 1) begin
                    pos_q   = '0;
                    phase_q = PH_NOP;
                end else begin
                    pos_q = pos + 8'd1;
                end
            end
            PH_NOP: begin
                c    = clamp_count(b, MAX_OPERATION_MODES_DEF);
                fid  = FID_OPM_COUNT;
                val  = {56'd0, c};
                emit = 1'b1;
                enter_section(c, PH_OPM, PH_DEF1);
            end
            PH_OPM: begin
                fid  = FID_OPM;
                idx  = pos;
                val  = {56'd0, b};
                emit = 1'b1;
                step_element(PH_DEF1);
            end
            PH_DEF1: begin
                fid     = FID_DEFECT;
                val     = {56'd0, b};
                emit    = 1'b1;
                phase_q = PH_DEF2;
            end
            PH_DEF2: begin
                fid     = FID_DEFECT_REASON;
                val     = {56'd0, b};
                emit    = 1'b1;
                phase_q = PH_VOLT;
            end
            PH_VOLT: begin
                fid     = FID_VOLTAGE;
                val     = {56'd0, b};
                emit    = 1'b1;
                phase_q = PH_TEMP;
            end
            PH_TEMP: begin
                fid     = FID_TEMPERATURE;
                val     = {56'd0, b};
                emit    = 1'b1;
                phase_q = PH_NIN;
            end
            PH_NIN: begin
                c    = clamp_count(b, MAX_INPUT_SIGNALS_DEF);
                fid  = FID_SIG_COUNT;
                val  = {56'd0, c};
                emit = 1'b1;
                enter_section(c, PH_INTYPE, PH_SYNC);
            end
            PH_INTYPE: begin
                fid  = FID_SIG_TYPE;
                idx  = pos;
                val  = {56'd0, b};
                emit = 1'b1;
                step_element(PH_INSTAT);
            end
            PH_INSTAT: begin
                fid  = FID_SIG_STATUS;
                idx  = pos;
                val  = {56'd0, b};
                emit = 1'b1;
                step_element(PH_SYNC);
            end
            PH_SYNC: begin
                fid     = FID_TIME_SYNC;
                val     = {56'd0, b};
                emit    = 1'b1;
                phase_q = PH_NCAL;
            end
            PH_NCAL: begin
                c    = clamp_count(b, MAX_CALIBRATION_PARTS_DEF);
                fid  = FID_CAL_COUNT;
                val  = {56'd0, c};
                emit = 1'b1;
                enter_section(c, PH_CALC, PH_DONE);
                if (c == 0) begin
                    complete_q = 1'b1;
                end
            end
            PH_CALC: begin
                fid  = FID_CAL_COMP;
                idx  = pos;
                val  = {56'd0, b};
                emit = 1'b1;
                step_element(PH_CALS);
            end
            PH_CALS: begin
                fid  = FID_CAL_STATUS;
                idx  = pos;
                val  = {56'd0, b};
                emit = 1'b1;
                step_element(PH_CALST);
            end
            PH_CALST: begin
                fid  = FID_CAL_STATE;
                idx  = pos;
                val  = {56'd0, b};
                emit = 1'b1;
                step_element(PH_DONE);
            end
            default: begin
                phase_q    = PH_DONE;
                complete_q = 1'b1;
            end
        endcase
        if (emit || item.last_byte) begin
            res.field_id      = fid;
            res.element_index = idx;
            res.field_value   = val;
            res.done_res      = item.last_byte;
            res.status        = item.last_byte && !complete_q;
            expected_fields.push_back(res);
        end
        if (item.last_byte) begin
            clear_decode_state();
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        logic      bad;
        if (expected_fields.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("ERROR: %0t unexpected id=%0d idx=%0d val=%h done=%0b status=%0b",
                         $time, got.field_id, got.element_index, got.field_value,
                         got.done_res, got.status);
            end
        end else begin
            want = expected_fields.pop_front();
            bad  = 1'b0;
            if (got.field_id !== want.field_id) bad = 1'b1;
            if (got.element_index !== want.element_index) bad = 1'b1;
            if (got.field_value !== want.field_value) bad = 1'b1;
            if (got.done_res !== want.done_res) bad = 1'b1;
            if (got.status !== want.status) bad = 1'b1;
            checked_count++;
            if (bad) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("ERROR: %0t expected id=%0d idx=%0d val=%h done=%0b status=%0b",
                             $time, want.field_id, want.element_index, want.field_value,
                             want.done_res, want.status);
                    $display("ERROR: %0t actual   id=%0d idx=%0d val=%h done=%0b status=%0b",
                             $time, got.field_id, got.element_index, got.field_value,
                             got.done_res, got.status);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_decode_state();
            expected_fields.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data);
            end
        end
        pending_count <= expected_fields.size();
    end

endmodule

`default_nettype wire

// File: dv/sensor_health_message_parser_top_tb.sv
`default_nettype none

module sensor_health_message_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shmp_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned PHASE_BYTES = 500;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned checked_count;

    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 64;
    int unsigned bytes_sent    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned n_complete    = 0;
    int unsigned n_cut         = 0;
    int unsigned n_noise       = 0;

    logic [7:0] msg_q[$];

    sensor_health_message_parser_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    shm_decode_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, last};
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        bytes_sent++;
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++) begin
            send_byte(msg_q[i], i == msg_q.size() - 1);
        end
    endtask

    function automatic int unsigned element_count(input logic [7:0] c, input int unsigned maxv);
        return (c > maxv) ? maxv : c;
    endfunction

    function automatic logic [7:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) return 8'd0;
        if (r < 75) return 8'($urandom_range(1, 4));
        if (r < 90) return 8'($urandom_range(15, 17));
        if (r < 96) return 8'($urandom_range(18, 254));
        return 8'd255;
    endfunction

    task automatic push_random(input int unsigned n);
        repeat (n) msg_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic build_wellformed();
        logic [7:0] c;
        msg_q.delete();
        push_random(HEADER_BYTES);
        c = pick_count();
        msg_q.push_back(c);
        push_random(element_count(c, MAX_OPERATION_MODES_DEF));
        push_random(4);
        c = pick_count();
        msg_q.push_back(c);
        push_random(2 * element_count(c, MAX_INPUT_SIGNALS_DEF));
        push_random(1);
        c = pick_count();
        msg_q.push_back(c);
        push_random(3 * element_count(c, MAX_CALIBRATION_PARTS_DEF));
        if ($urandom_range(99) < 30) begin
            push_random($urandom_range(1, 4));
        end
    endtask

    task automatic run_random(input int unsigned n_bytes);
        int unsigned goal;
        int unsigned r;
        int unsigned cut;
        goal = bytes_sent + n_bytes;
        while (bytes_sent < goal) begin
            r = $urandom_range(99);
            if (r < 60) begin
                build_wellformed();
                n_complete++;
            end else if (r < 85) begin
                build_wellformed();
                cut = $urandom_range(1, msg_q.size() - 1);
                while (msg_q.size() > cut) void'(msg_q.pop_back());
                n_cut++;
            end else begin
                msg_q.delete();
                push_random($urandom_range(1, 40));
                n_noise++;
            end
            send_message();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        msg_q.delete();
        msg_q.push_back(8'h00);
        send_message();
        n_cut++;

        msg_q.delete();
        repeat (8) msg_q.push_back(8'hFF);
        send_message();
        n_cut++;

        // Smallest complete message: every count is zero.
        msg_q.delete();
        for (int i = 0; i < HEADER_BYTES; i++) begin
            msg_q.push_back((i % 2) ? 8'h00 : 8'hFF);
        end
        msg_q.push_back(8'h00);
        repeat (4) msg_q.push_back(8'hFF);
        msg_q.push_back(8'h00);
        msg_q.push_back(8'hFF);
        msg_q.push_back(8'h00);
        send_message();
        n_complete++;

        run_random(PHASE_BYTES);
        send_idle_pct = 64;
        recv_idle_pct = 6;
        run_random(PHASE_BYTES);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_BYTES);

        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_count == 0);
        repeat (20) @(posedge aclk);

        $display("Sent %0d bytes in %0d messages: %0d well-formed, %0d cut short, %0d noise.",
                 bytes_sent, n_complete + n_cut + n_noise, n_complete, n_cut, n_noise);
        $display("Checked %0d decoded fields under three idle and stall profiles.",
                 checked_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sensor_health_message_parser_top.f
rtl/shmp_pkg.sv
rtl/shmp_decoder.sv
rtl/sensor_health_message_parser_top.sv
dv/shm_decode_checker.sv
dv/sensor_health_message_parser_top_tb.sv
